[rtl/core/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is low.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, switched off while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds through reset.
`define ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/prfe_pkg.sv]
package prfe_pkg;

  localparam logic [1:0] ACT_PLOT = 2'd0;
  localparam logic [1:0] ACT_FILL = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [7:0]  LINE_BYTES_RESET = 8'd80;
  localparam logic [15:0] EDGE_LEFT        = 16'h00FF;
  localparam logic [15:0] EDGE_RIGHT       = 16'hFF80;
  localparam logic [7:0]  PIXEL_MSB        = 8'h80;
  localparam logic [7:0]  FULL_BYTE        = 8'hFF;

  localparam int unsigned COLOUR_PLANES = 4;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic calc;
    logic chk;
    logic rd;
    logic wr;
    logic grab;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic reject;
    logic is_read;
    logic last_byte;
    logic last_row;
    logic out_full;
  } sts_t;

endpackage

[rtl/core/prfe_if.sv]
interface prfe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [9:0]  pos_x;
  logic [9:0]  pos_y;
  logic [10:0] rect_width;
  logic [10:0] rect_height;
  logic [3:0]  colour;
  logic [1:0]  plane_select;

  modport source (output valid, action, pos_x, pos_y, rect_width, rect_height, colour,
                  plane_select, input ready);
  modport sink (input valid, action, pos_x, pos_y, rect_width, rect_height, colour,
                plane_select, output ready);
endinterface

interface prfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       status;

  modport source (output valid, read_data, status, input ready);
  modport sink (input valid, read_data, status, output ready);
endinterface

[rtl/core/prfe_ctrl.sv]
module prfe_ctrl
  import prfe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_WR   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        state_nxt = sts.reject ? S_DONE : S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        if (sts.is_read) begin
          cmd.grab  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.wr    = 1'b1;
          state_nxt = (sts.last_byte && sts.last_row) ? S_DONE : S_RD;
        end
      end
      S_DONE: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

endmodule

[rtl/core/prfe_datapath.sv]
module prfe_datapath
  import prfe_pkg::*;
#(
  parameter int unsigned PLANE_BYTES = 65536,
  parameter int unsigned NUM_PLANES  = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [7:0]  line_bytes,
  input  logic [1:0]  in_action,
  input  logic [9:0]  in_pos_x,
  input  logic [9:0]  in_pos_y,
  input  logic [10:0] in_rect_width,
  input  logic [10:0] in_rect_height,
  input  logic [3:0]  in_colour,
  input  logic [1:0]  in_plane_select,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [7:0]  out_read_data,
  output logic        out_status
);

  localparam int unsigned AW = $clog2(PLANE_BYTES);
  localparam int unsigned DW = NUM_PLANES * 8;
  localparam logic [20:0] PB_LIMIT = 21'(PLANE_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(PLANE_BYTES - 1);

  logic [DW-1:0] mem [PLANE_BYTES];

  logic [1:0]  act_r;
  logic [9:0]  x_r, y_r;
  logic [10:0] w_r, h_r;
  logic [3:0]  col_r;
  logic [1:0]  psel_r;
  logic [19:0] prod_r, prod2_r;
  logic [20:0] off_r;
  logic [8:0]  byte_r, nb_last_r;
  logic [10:0] row_r, row_last_r;
  logic [7:0]  lmask_r, rmask_r;
  logic        reject_r;
  logic [DW-1:0] rdata_r;
  logic [7:0]  rbyte_r;
  logic [AW-1:0] clr_cnt_r;
  logic        valid_r;
  logic [7:0]  odata_r;
  logic        ostat_r;

  logic [11:0] x2;
  logic [11:0] y_end;
  logic [20:0] base, last;
  logic [20:0] addr;
  logic [7:0]  mask;
  logic [DW-1:0] wdata;
  logic [7:0]  sel_byte;

  assign x2    = 12'(x_r) + 12'(w_r) - 12'd1;
  assign y_end = 12'(y_r) + 12'(h_r) - 12'd1;
  assign base  = 21'(prod_r) + 21'(x_r[9:3]);
  assign last  = 21'(prod2_r) + 21'(x2[11:3]);
  assign addr  = off_r + 21'(byte_r);

  always_comb begin
    if (byte_r == 9'd0) begin
      mask = (nb_last_r == 9'd0) ? (lmask_r & rmask_r) : lmask_r;
    end else if (byte_r == nb_last_r) begin
      mask = rmask_r;
    end else begin
      mask = FULL_BYTE;
    end
  end

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    localparam int unsigned CB = p % COLOUR_PLANES;
    logic set;
    assign set = (p < COLOUR_PLANES) ? col_r[CB] : 1'b0;
    assign wdata[p*8 +: 8] = set ? (rdata_r[p*8 +: 8] | mask)
                                 : (rdata_r[p*8 +: 8] & ~mask);
  end

  always_comb begin
    sel_byte = '0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      if (32'(psel_r) == p) sel_byte = rdata_r[p*8 +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.wr) begin
      mem[addr[AW-1:0]] <= wdata;
    end
    if (cmd.rd) rdata_r <= mem[addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= in_action;
      x_r     <= in_pos_x;
      y_r     <= in_pos_y;
      w_r     <= in_rect_width;
      h_r     <= in_rect_height;
      col_r   <= in_colour;
      psel_r  <= in_plane_select;
      rbyte_r <= '0;
    end
    if (cmd.calc) begin
      prod_r  <= 20'(line_bytes) * 20'(y_r);
      prod2_r <= 20'(line_bytes) * 20'(y_end);
    end
    if (cmd.chk) begin
      off_r  <= base;
      byte_r <= '0;
      row_r  <= '0;
      unique case (act_r)
        ACT_PLOT: begin
          reject_r   <= (base >= PB_LIMIT);
          lmask_r    <= PIXEL_MSB >> x_r[2:0];
          rmask_r    <= FULL_BYTE;
          nb_last_r  <= '0;
          row_last_r <= '0;
        end
        ACT_FILL: begin
          reject_r   <= (w_r == '0) || (h_r == '0) || (last >= PB_LIMIT);
          lmask_r    <= 8'(EDGE_LEFT >> x_r[2:0]);
          rmask_r    <= 8'(EDGE_RIGHT >> x2[2:0]);
          nb_last_r  <= x2[11:3] - 9'(x_r[9:3]);
          row_last_r <= h_r - 11'd1;
        end
        ACT_READ: begin
          reject_r   <= (32'(psel_r) >= NUM_PLANES) || (base >= PB_LIMIT);
          lmask_r    <= '0;
          rmask_r    <= '0;
          nb_last_r  <= '0;
          row_last_r <= '0;
        end
        default: begin
          reject_r   <= 1'b1;
          lmask_r    <= '0;
          rmask_r    <= '0;
          nb_last_r  <= '0;
          row_last_r <= '0;
        end
      endcase
    end
    if (cmd.wr) begin
      if (byte_r == nb_last_r) begin
        byte_r <= '0;
        row_r  <= row_r + 11'd1;
        off_r  <= off_r + 21'(line_bytes);
      end else begin
        byte_r <= byte_r + 9'd1;
      end
    end
    if (cmd.grab) rbyte_r <= sel_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      odata_r <= rbyte_r;
      ostat_r <= reject_r;
    end
  end

  assign sts.clr_last  = (clr_cnt_r == CLR_LAST);
  assign sts.reject    = reject_r;
  assign sts.is_read   = (act_r == ACT_READ);
  assign sts.last_byte = (byte_r == nb_last_r);
  assign sts.last_row  = (row_r == row_last_r);
  assign sts.out_full  = valid_r && !out_ready;

  assign out_valid     = valid_r;
  assign out_read_data = odata_r;
  assign out_status    = ostat_r;

endmodule

[rtl/core/planar_rect_fill_engine.sv]
// Channel   Direction  Beat contents
// in_chan   sink       action, pos_x, pos_y, rect_width, rect_height, colour, plane_select
// out_chan  source     read_data, status
// cfg_*     APB slave  line_bytes at byte address 0
//
// A plot or a read passes the calc, check and decide states, one memory read, then a write
// or a grab, then the result; a fill does a read-modify-write of every byte of every row on
// the single memory port. A rejected item skips the memory. One item is in work at a time.
// After reset a clearing pass zeroes the store at one address a cycle, with in_chan.ready low;
// configuration writes are taken throughout.
// A result waits in the output register while out_chan stalls, and the next item is
// accepted meanwhile.
module planar_rect_fill_engine
  import prfe_pkg::*;
#(
  parameter int unsigned PLANE_BYTES = 65536,
  parameter int unsigned NUM_PLANES  = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  prfe_in_if.sink     in_chan,
  prfe_out_if.source  out_chan,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // The one register, the scan line stride, lives here with the bus decode.
  logic [7:0] line_bytes_r;
  logic       cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_bytes_r <= LINE_BYTES_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_hit) begin
      line_bytes_r <= cfg_pwdata[7:0];
    end
  end

  assign cfg_prdata = cfg_hit ? {24'd0, line_bytes_r} : 32'd0;

  // The controller sequences the clearing pass, the address checks and the byte walk;
  // the datapath holds the item, the plane store and the result register.
  cmd_t cmd;
  sts_t sts;

  prfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  prfe_datapath #(
    .PLANE_BYTES (PLANE_BYTES),
    .NUM_PLANES  (NUM_PLANES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .line_bytes      (line_bytes_r),
    .in_action       (in_chan.action),
    .in_pos_x        (in_chan.pos_x),
    .in_pos_y        (in_chan.pos_y),
    .in_rect_width   (in_chan.rect_width),
    .in_rect_height  (in_chan.rect_height),
    .in_colour       (in_chan.colour),
    .in_plane_select (in_chan.plane_select),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .out_read_data   (out_chan.read_data),
    .out_status      (out_chan.status)
  );

endmodule

[rtl/core/prfe_checker.sv]
`include "assert_macros.svh"

module prfe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic       out_status
);

  // A rejected item never carries read data.
  `ASSERT_SAME(a_reject_zero, clk, rst_n, out_valid && out_status, out_read_data == 8'd0)
  // A stalled result beat stays offered.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // Only one item is in work, so an accepted beat closes the input for the next cycle.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  // Reset empties the result register.
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind planar_rect_fill_engine prfe_checker u_prfe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_read_data (out_chan.read_data),
  .out_status    (out_chan.status)
);

[test/planar_rect_fill_engine_tb.sv]
`timescale 1ns / 100ps

module planar_rect_fill_engine_tb;
  import prfe_pkg::*;

  // Geometry of the block as built with its default parameters.
  localparam int unsigned STORE_BYTES = 65536;
  localparam int unsigned PLANE_COUNT = 4;

  // Register map of the configuration port.
  localparam logic [2:0] REG_LINE_BYTES = 3'd0;

  // The action code that the block does not know.
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  // Result status codes.
  localparam logic STAT_DONE   = 1'b0;
  localparam logic STAT_REJECT = 1'b1;

  // One drawing command as it travels on the input channel.
  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic [10:0] rect_width;
    logic [10:0] rect_height;
    logic [3:0]  colour;
    logic [1:0]  plane_select;
  } draw_cmd_t;

  // One reply as it travels on the result channel.
  typedef struct packed {
    logic [7:0] read_data;
    logic       status;
  } draw_reply_t;

  // A row of the directed table. Where fixed is set, the reply is typed in by hand.
  typedef struct packed {
    draw_cmd_t   cmd;
    logic        fixed;
    draw_reply_t reply;
  } table_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  prfe_in_if  in_chan ();
  prfe_out_if out_chan ();

  planar_rect_fill_engine DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Shadow copy of the framebuffer planes and of the stride register.
  logic [7:0]  shadow_planes [PLANE_COUNT][STORE_BYTES];
  int unsigned shadow_stride;

  // Replies that the block still owes, oldest first.
  draw_reply_t pending_replies [$];
  table_row_t  directed_rows [$];
  int          fail_count;

  // Receiver controls: a request for one long hold-off and a switch for stretches with the
  // output always ready; in_calm is the sender's switch for runs without gaps.
  bit          long_hold_req;
  bit          out_calm;
  bit          in_calm;

  // The clock runs at a 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Sets or clears the masked bits of one byte, ignoring bytes past the plane.
  task automatic paint_byte(input int unsigned plane, input int unsigned addr,
                            input logic [7:0] mask, input bit set);
    if (plane < PLANE_COUNT && addr < STORE_BYTES) begin
      if (set) begin
        shadow_planes[plane][addr] = shadow_planes[plane][addr] | mask;
      end else begin
        shadow_planes[plane][addr] = shadow_planes[plane][addr] & ~mask;
      end
    end
  endtask

  // Works out the reply to one command and applies its effect to the shadow planes.
  task automatic draw_and_reply(input draw_cmd_t cmd, output draw_reply_t reply);
    int unsigned x, y, wd, ht, x2, addr, nbytes, off, row, k, p;
    logic [7:0]  lmask, rmask, pmask;
    bit          set;
    x = cmd.pos_x;
    y = cmd.pos_y;
    wd = cmd.rect_width;
    ht = cmd.rect_height;
    reply.read_data = 8'h00;
    reply.status = STAT_REJECT;
    case (cmd.action)
      ACT_PLOT: begin
        addr = shadow_stride * y + (x >> 3);
        pmask = PIXEL_MSB >> (x & 7);
        if (addr < STORE_BYTES) begin
          for (p = 0; p < PLANE_COUNT; p++) begin
            paint_byte(p, addr, pmask, (p < 4) ? cmd.colour[p] : 1'b0);
          end
          reply.status = STAT_DONE;
        end
      end
      ACT_FILL: begin
        if (wd != 0 && ht != 0) begin
          x2 = x + wd - 1;
          if (shadow_stride * (y + ht - 1) + (x2 >> 3) < STORE_BYTES) begin
            nbytes = (x2 >> 3) - (x >> 3) + 1;
            lmask = 8'(EDGE_LEFT >> (x & 7));
            rmask = 8'(EDGE_RIGHT >> (x2 & 7));
            if (nbytes == 1) begin
              lmask = lmask & rmask;
            end
            for (p = 0; p < PLANE_COUNT; p++) begin
              set = (p < 4) ? cmd.colour[p] : 1'b0;
              off = shadow_stride * y + (x >> 3);
              // Rows go top to bottom, so overlapping rows keep the last write.
              for (row = 0; row < ht; row++) begin
                paint_byte(p, off, lmask, set);
                for (k = 1; k + 1 < nbytes; k++) begin
                  paint_byte(p, off + k, FULL_BYTE, set);
                end
                if (nbytes > 1) begin
                  paint_byte(p, off + nbytes - 1, rmask, set);
                end
                off += shadow_stride;
              end
            end
            reply.status = STAT_DONE;
          end
        end
      end
      ACT_READ: begin
        addr = shadow_stride * y + (x >> 3);
        if (cmd.plane_select < PLANE_COUNT && addr < STORE_BYTES) begin
          reply.read_data = shadow_planes[cmd.plane_select][addr];
          reply.status = STAT_DONE;
        end
      end
      default: begin
        reply.status = STAT_REJECT;
      end
    endcase
  endtask

  function automatic draw_cmd_t make_cmd(input logic [1:0] action, input int x, input int y,
                                         input int wd, input int ht, input int colour,
                                         input int plane);
    draw_cmd_t cmd;
    cmd.action = action;
    cmd.pos_x = 10'(x);
    cmd.pos_y = 10'(y);
    cmd.rect_width = 11'(wd);
    cmd.rect_height = 11'(ht);
    cmd.colour = 4'(colour);
    cmd.plane_select = 2'(plane);
    return cmd;
  endfunction

  task automatic add_row(input draw_cmd_t cmd, input bit fixed, input int data,
                         input logic status);
    table_row_t row;
    row.cmd = cmd;
    row.fixed = fixed;
    row.reply.read_data = 8'(data);
    row.reply.status = status;
    directed_rows.push_back(row);
  endtask

  // Sender gaps: mostly none or short, now and then a long one.
  function automatic int pick_gap(input bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  // Random command for the current stride. Most of them land in range, half of those near the
  // top-left corner, so that reads find pixels that were drawn before.
  function automatic draw_cmd_t random_cmd(input int unsigned stride);
    draw_cmd_t   cmd;
    int unsigned roll, ymax;
    roll = $urandom_range(0, 99);
    ymax = (stride == 0) ? 1023 : (STORE_BYTES / stride);
    if (ymax > 1023) begin
      ymax = 1023;
    end
    cmd = make_cmd(ACT_PLOT, 0, 0, 0, 0, 0, 0);
    cmd.rect_width = 11'($urandom_range(0, 2047));
    cmd.rect_height = 11'($urandom_range(0, 2047));
    cmd.colour = 4'($urandom_range(0, 15));
    cmd.plane_select = 2'($urandom_range(0, 3));
    if (roll < 4) begin
      // Noise: any action, any position, any size, but a fill no taller than 3 rows.
      cmd.action = 2'($urandom_range(0, 3));
      cmd.pos_x = 10'($urandom_range(0, 1023));
      cmd.pos_y = 10'($urandom_range(0, 1023));
      if (cmd.action == ACT_FILL) begin
        cmd.rect_height = 11'($urandom_range(0, 3));
      end
      return cmd;
    end
    if ($urandom_range(0, 1) == 0) begin
      cmd.pos_x = 10'($urandom_range(0, 63));
      cmd.pos_y = 10'($urandom_range(0, (ymax < 15) ? ymax : 15));
    end else begin
      cmd.pos_x = 10'($urandom_range(0, 1023));
      cmd.pos_y = 10'($urandom_range(0, ymax));
    end
    if (roll < 40) begin
      cmd.action = ACT_PLOT;
    end else if (roll < 70) begin
      cmd.action = ACT_READ;
    end else if (roll < 97) begin
      cmd.action = ACT_FILL;
      cmd.rect_width = 11'($urandom_range(1, 40));
      cmd.rect_height = 11'($urandom_range(1, 8));
      if ($urandom_range(0, 30) == 0) begin
        cmd.rect_width = 11'($urandom_range(1000, 1024));
        cmd.rect_height = 11'(1);
      end
      if ($urandom_range(0, 30) == 0) begin
        cmd.rect_height = 11'(0);
      end
    end else begin
      cmd.action = ACT_UNKNOWN;
    end
    return cmd;
  endfunction

  // Offers one command and holds it until it is taken. The reply is predicted
  // at the edge where the beat is accepted, then the sender idles for a while.
  task automatic offer_cmd(input draw_cmd_t cmd, input bit fixed,
                           input draw_reply_t typed_reply, input int gap);
    draw_reply_t reply;
    @(negedge clk);
    in_chan.valid = 1'b1;
    in_chan.action = cmd.action;
    in_chan.pos_x = cmd.pos_x;
    in_chan.pos_y = cmd.pos_y;
    in_chan.rect_width = cmd.rect_width;
    in_chan.rect_height = cmd.rect_height;
    in_chan.colour = cmd.colour;
    in_chan.plane_select = cmd.plane_select;
    do begin
      @(posedge clk);
    end while (!in_chan.ready);
    draw_and_reply(cmd, reply);
    pending_replies.push_back(fixed ? typed_reply : reply);
    if (gap > 0) begin
      @(negedge clk);
      in_chan.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // One APB transfer: the setup phase, then the access phase.
  task automatic cfg_access(input bit write, input logic [2:0] addr, input logic [31:0] data,
                            output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = write;
    cfg_paddr = addr;
    cfg_pwdata = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // Writes the stride, reads it back and updates the shadow copy.
  task automatic set_stride(input int unsigned value);
    logic [31:0] rdata;
    cfg_access(1'b1, REG_LINE_BYTES, 32'(value & 8'hFF), rdata);
    cfg_access(1'b0, REG_LINE_BYTES, 32'h0, rdata);
    if (rdata[7:0] !== 8'(value)) begin
      $error("line_bytes readback: expected %0d, actual %0d", value & 8'hFF, rdata[7:0]);
      fail_count++;
    end
    shadow_stride = value & 8'hFF;
  endtask

  // Receiver: random hold-offs, mostly short and a few long, plus one long hold-off
  // on request that lets the block fill up and stall its input.
  initial begin : receiver
    int hold_left;
    int roll;
    hold_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_chan.ready = 1'b0;
        hold_left--;
      end else begin
        out_chan.ready = 1'b1;
        roll = $urandom_range(0, 99);
        if (!out_calm && roll < 25) begin
          hold_left = (roll < 3) ? $urandom_range(15, 50) : $urandom_range(1, 3);
        end
      end
    end
  end

  // Every reply beat is compared with the oldest one still owed.
  always @(posedge clk) begin
    draw_reply_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_replies.size() == 0) begin
        $error("reply beat with nothing owed: read_data %0h status %0d",
               out_chan.read_data, out_chan.status);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (out_chan.read_data !== want.read_data) begin
          $error("read_data: expected %0h, actual %0h", want.read_data, out_chan.read_data);
          fail_count++;
        end
        if (out_chan.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_chan.status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog, sized for the clearing pass, one full-screen fill and many stalls.
  initial begin : watchdog
    #40ms;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned strides [6];
    int          phase;
    int          n;
    draw_reply_t no_reply;
    table_row_t  row;

    fail_count = 0;
    long_hold_req = 1'b0;
    out_calm = 1'b0;
    in_calm = 1'b0;
    no_reply = '0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.action = ACT_PLOT;
    in_chan.pos_x = '0;
    in_chan.pos_y = '0;
    in_chan.rect_width = '0;
    in_chan.rect_height = '0;
    in_chan.colour = '0;
    in_chan.plane_select = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      for (int a = 0; a < STORE_BYTES; a++) begin
        shadow_planes[p][a] = 8'h00;
      end
    end
    shadow_stride = LINE_BYTES_RESET;

    // Directed table at the reset stride of 80 bytes.
    add_row(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0), 1, 8'h00, STAT_DONE);
    add_row(make_cmd(ACT_READ, 1023, 817, 0, 0, 0, 3), 1, 8'h00, STAT_DONE);
    // The first byte past the plane, for a read and for a plot.
    add_row(make_cmd(ACT_READ, 768, 818, 0, 0, 0, 3), 1, 8'h00, STAT_REJECT);
    add_row(make_cmd(ACT_PLOT, 768, 818, 0, 0, 15, 0), 1, 8'h00, STAT_REJECT);
    add_row(make_cmd(ACT_UNKNOWN, 5, 5, 3, 3, 15, 1), 1, 8'h00, STAT_REJECT);
    // Empty rectangles, then one that runs past the plane.
    add_row(make_cmd(ACT_FILL, 8, 1, 0, 4, 15, 0), 1, 8'h00, STAT_REJECT);
    add_row(make_cmd(ACT_FILL, 8, 1, 4, 0, 15, 0), 1, 8'h00, STAT_REJECT);
    add_row(make_cmd(ACT_FILL, 1023, 1023, 1024, 1024, 15, 0), 1, 8'h00, STAT_REJECT);
    add_row(make_cmd(ACT_PLOT, 0, 0, 0, 0, 15, 0), 1, 8'h00, STAT_DONE);
    add_row(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0), 1, 8'h80, STAT_DONE);
    add_row(make_cmd(ACT_PLOT, 7, 0, 0, 0, 5, 0), 0, 0, STAT_DONE);
    add_row(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 1), 0, 0, STAT_DONE);
    add_row(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 2), 0, 0, STAT_DONE);
    add_row(make_cmd(ACT_PLOT, 1023, 0, 0, 0, 3, 0), 0, 0, STAT_DONE);
    // Both edge masks inside one byte, then a span over several bytes.
    add_row(make_cmd(ACT_FILL, 3, 2, 2, 3, 10, 0), 0, 0, STAT_DONE);
    add_row(make_cmd(ACT_READ, 0, 3, 0, 0, 0, 1), 0, 0, STAT_DONE);
    add_row(make_cmd(ACT_FILL, 5, 6, 30, 4, 9, 0), 0, 0, STAT_DONE);
    add_row(make_cmd(ACT_READ, 16, 7, 0, 0, 0, 3), 0, 0, STAT_DONE);
    // A row wider than the line runs on into the next line.
    add_row(make_cmd(ACT_FILL, 0, 10, 1024, 1, 15, 0), 0, 0, STAT_DONE);
    add_row(make_cmd(ACT_READ, 0, 11, 0, 0, 0, 2), 0, 0, STAT_DONE);
    // The whole screen, down to the last row that fits in the plane.
    add_row(make_cmd(ACT_FILL, 0, 0, 640, 819, 6, 0), 0, 0, STAT_DONE);
    add_row(make_cmd(ACT_READ, 639, 818, 0, 0, 0, 1), 0, 0, STAT_DONE);
    add_row(make_cmd(ACT_FILL, 9, 1, 20, 3, 0, 0), 0, 0, STAT_DONE);
    add_row(make_cmd(ACT_READ, 16, 2, 0, 0, 0, 2), 0, 0, STAT_DONE);

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // The stride is written with its reset value during the clearing pass.
    set_stride(LINE_BYTES_RESET);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      offer_cmd(row.cmd, row.fixed, row.reply, pick_gap(1'b0));
    end

    // Random phases, one per stride setting, the extremes among them.
    strides[0] = 1;
    strides[1] = 128;
    strides[2] = 0;
    strides[3] = 255;
    strides[4] = $urandom_range(2, 127);
    strides[5] = LINE_BYTES_RESET;
    for (phase = 0; phase < 6; phase++) begin
      // The block is idle only once every owed reply has come back.
      @(negedge clk);
      in_chan.valid = 1'b0;
      wait (pending_replies.size() == 0);
      set_stride(strides[phase]);
      out_calm = (phase == 4);
      in_calm = (phase == 4);
      if (shadow_stride == 0) begin
        // With a zero stride every row lands on line 0, even for a tall rectangle.
        offer_cmd(make_cmd(ACT_FILL, 12, 900, 9, 1024, 11, 0), 0, no_reply, 0);
        offer_cmd(make_cmd(ACT_READ, 16, 3, 0, 0, 0, 3), 0, no_reply, 0);
      end
      for (n = 0; n < 105; n++) begin
        if (phase == 1 && n == 30) begin
          // Long hold-off on the output while commands keep coming.
          long_hold_req = 1'b1;
        end
        if (phase == 3 && n == 50) begin
          // The sender rests until the block has answered everything.
          @(negedge clk);
          in_chan.valid = 1'b0;
          wait (pending_replies.size() == 0);
        end
        offer_cmd(random_cmd(shadow_stride), 0, no_reply, pick_gap(in_calm));
      end
    end

    @(negedge clk);
    in_chan.valid = 1'b0;
    wait (pending_replies.size() == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
